// ----- sv/wlca_pkg.sv -----
// Package for the weighted LCA binary lifting core.
// Payload structs, widths, command/status types. No dependencies.
`timescale 1ns / 1ps
package wlca_pkg;
	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF = 10;
	localparam int ID_W = 10;
	localparam int WSUM_W = 42;
	localparam int EW_W = 32;
	localparam int DEPTH_W = 10;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [ID_W-1:0] node_id;
		logic [ID_W-1:0] other_node;
		logic [EW_W-1:0] edge_weight;
		logic is_root;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] common_ancestor;
		logic [WSUM_W-1:0] dist_sum;
	} out_item_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE = 4'd0,
		CMD_LOAD = 4'd1,   // latch input item
		CMD_RD_DEPTH = 4'd2,   // read depth of a and b (or parent)
		CMD_ADD_BASE = 4'd3,   // write level 0 and depth
		CMD_ADD_RD = 4'd4,   // read node(k-1) entry
		CMD_ADD_RD2 = 4'd5,   // read mid(k-1) entry
		CMD_ADD_WR = 4'd6,   // write level k
		CMD_SWAP = 4'd7,   // order a deeper than b
		CMD_L1_RD = 4'd8,   // read a at level i
		CMD_L1_EV = 4'd9,   // evaluate first-pass lift
		CMD_L2_RD = 4'd10,  // read a and b at level i
		CMD_L2_EV = 4'd11,  // evaluate joint lift
		CMD_FIN = 4'd12   // final parent step
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [3:0] level;
	} cmd_t;

	typedef struct packed {
		logic query;
		logic in_range;
		logic a_eq_b;
	} stat_t;
endpackage

// ----- sv/wlca_datapath.sv -----
// Datapath of the weighted LCA core: node tables and walk registers.
// Depends on wlca_pkg. Driven by wlca_ctrl through cmd_t / stat_t.
`timescale 1ns / 1ps
module wlca_datapath #(
	parameter int MAX_NODES = wlca_pkg::MAX_NODES_DEF,
	parameter int LEVELS = wlca_pkg::LEVELS_DEF
) (
	input logic clk,
	input wlca_pkg::in_item_t item,
	input wlca_pkg::cmd_t cmd,
	output wlca_pkg::stat_t stat,
	output wlca_pkg::out_item_t result
);
	import wlca_pkg::*;
	localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOTS = MAX_NODES * LEVELS;
	localparam int SLOT_W = $clog2(SLOTS);

	logic [ID_W:0] anc_mem_a [SLOTS];
	logic [ID_W:0] anc_mem_b [SLOTS];
	logic [WSUM_W-1:0] dist_mem_a [SLOTS];
	logic [WSUM_W-1:0] dist_mem_b [SLOTS];
	logic [DEPTH_W-1:0] depth_mem_a [MAX_NODES];
	logic [DEPTH_W-1:0] depth_mem_b [MAX_NODES];

	logic [ID_W-1:0] a_q, b_q;
	logic [EW_W-1:0] w_q;
	logic root_q, query_q;
	logic [DEPTH_W-1:0] da_q, db_q;
	logic [ID_W:0] la_q, lb_q;
	logic [WSUM_W-1:0] wa_q, wb_q, prevw_q, total_q;
	logic [ID_W-1:0] res_anc_q;

	logic [SLOT_W-1:0] ra, rb, wr;
	logic [NODE_W-1:0] rda, rdb;
	logic we, wd;
	logic [ID_W:0] wanc;
	logic [WSUM_W-1:0] wdist;
	logic [DEPTH_W-1:0] wdep;
	logic [NODE_W-1:0] wnode;
	logic [LVL_W-1:0] lvl;
	logic [LVL_W-1:0] lvl_m1;
	logic la_ok, lb_ok;
	logic [DEPTH_W+16:0] need;

	function automatic logic [SLOT_W-1:0] slot(input logic [ID_W-1:0] n,
			input logic [LVL_W-1:0] l);
		logic [SLOT_W+ID_W:0] s;
		s = (SLOT_W + ID_W + 1)'(n) * (SLOT_W + ID_W + 1)'(LEVELS) + (SLOT_W + ID_W + 1)'(l);
		return s[SLOT_W-1:0];
	endfunction

	assign lvl = cmd.level[LVL_W-1:0];
	assign lvl_m1 = lvl - LVL_W'(1);
	assign la_ok = la_q[ID_W] && (32'(la_q[ID_W-1:0]) < 32'(MAX_NODES));
	assign lb_ok = lb_q[ID_W] && (32'(lb_q[ID_W-1:0]) < 32'(MAX_NODES));
	assign need = (DEPTH_W + 17)'(db_q) + ((DEPTH_W + 17)'(1) << cmd.level);

	always_comb begin
		ra = slot(a_q, lvl);
		rb = slot(b_q, lvl);
		rda = a_q[NODE_W-1:0];
		rdb = b_q[NODE_W-1:0];
		we = 1'b0;
		wd = 1'b0;
		wr = slot(a_q, lvl);
		wanc = '0;
		wdist = '0;
		wnode = a_q[NODE_W-1:0];
		wdep = '0;
		case (cmd.op)
			CMD_ADD_BASE: begin
				we = 1'b1;
				wd = 1'b1;
				wr = slot(a_q, '0);
				wanc = root_q ? '0 : {1'b1, b_q};
				wdist = root_q ? '0 : WSUM_W'(w_q);
				wdep = root_q ? '0 : db_q + DEPTH_W'(1);
			end
			CMD_ADD_RD: ra = slot(a_q, lvl_m1);
			CMD_ADD_RD2: ra = slot(la_q[ID_W-1:0], lvl_m1);
			CMD_ADD_WR: begin
				we = 1'b1;
				wanc = la_ok ? lb_q : '0;
				wdist = la_ok ? prevw_q + wb_q : '0;
			end
			CMD_FIN: begin
				ra = slot(a_q, '0);
				rb = slot(b_q, '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			anc_mem_a[wr] <= wanc;
			anc_mem_b[wr] <= wanc;
			dist_mem_a[wr] <= wdist;
			dist_mem_b[wr] <= wdist;
		end
		if (wd) begin
			depth_mem_a[wnode] <= wdep;
			depth_mem_b[wnode] <= wdep;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				a_q <= item.node_id;
				b_q <= item.other_node;
				w_q <= item.edge_weight;
				root_q <= item.is_root;
				query_q <= (item.opcode == OP_QUERY);
				total_q <= '0;
			end
			CMD_RD_DEPTH: begin
				da_q <= depth_mem_a[rda];
				db_q <= depth_mem_b[rdb];
			end
			CMD_ADD_RD: begin
				la_q <= anc_mem_a[ra];
				prevw_q <= dist_mem_a[ra];
			end
			CMD_ADD_RD2: begin
				lb_q <= anc_mem_b[ra];
				wb_q <= dist_mem_b[ra];
			end
			CMD_SWAP: begin
				if (da_q < db_q) begin
					a_q <= b_q;
					b_q <= a_q;
					da_q <= db_q;
					db_q <= da_q;
				end
			end
			CMD_L1_RD: begin
				da_q <= depth_mem_a[rda];
				la_q <= anc_mem_a[ra];
				wa_q <= dist_mem_a[ra];
				lb_q <= anc_mem_b[rb];
				wb_q <= dist_mem_b[rb];
			end
			CMD_L2_RD, CMD_FIN: begin
				la_q <= anc_mem_a[ra];
				wa_q <= dist_mem_a[ra];
				lb_q <= anc_mem_b[rb];
				wb_q <= dist_mem_b[rb];
			end
			CMD_L1_EV: begin
				if ((DEPTH_W + 17)'(da_q) >= need && la_ok) begin
					total_q <= total_q + wa_q;
					a_q <= la_q[ID_W-1:0];
				end
			end
			CMD_L2_EV: begin
				if (la_q != lb_q && la_ok && lb_ok) begin
					total_q <= total_q + wa_q + wb_q;
					a_q <= la_q[ID_W-1:0];
					b_q <= lb_q[ID_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign stat.query = query_q;
	assign stat.in_range = (32'(a_q) < 32'(MAX_NODES)) && (32'(b_q) < 32'(MAX_NODES));
	assign stat.a_eq_b = (a_q == b_q);
	assign res_anc_q = la_q[ID_W] ? la_q[ID_W-1:0] : '0;
	assign result.common_ancestor = stat.a_eq_b ? a_q : res_anc_q;
	assign result.dist_sum = stat.a_eq_b ? total_q : total_q + wa_q + wb_q;
endmodule

// ----- sv/wlca_ctrl.sv -----
// Controller of the weighted LCA core: sequences adds and queries.
// Depends on wlca_pkg. Drives wlca_datapath, owns the handshakes.
`timescale 1ns / 1ps
module wlca_ctrl #(
	parameter int LEVELS = wlca_pkg::LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input wlca_pkg::stat_t stat,
	output wlca_pkg::cmd_t cmd,
	output logic capture
);
	import wlca_pkg::*;
	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_DEPTH = 12'b000000000010,
		S_ABASE = 12'b000000000100,
		S_ARD = 12'b000000001000,
		S_ARD2 = 12'b000000010000,
		S_AWR = 12'b000000100000,
		S_SWAP = 12'b000001000000,
		S_L1RD = 12'b000010000000,
		S_L1EV = 12'b000100000000,
		S_L2RD = 12'b001000000000,
		S_L2EV = 12'b010000000000,
		S_FIN = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [3:0] lvl_q;
	logic fin_q;
	logic busy_out_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid && !fin_q;
	assign out_valid = busy_out_q;

	always_comb begin
		cmd.level = lvl_q;
		cmd.op = CMD_NONE;
		case (state_q)
			S_IDLE: cmd.op = (in_valid && in_ready) ? CMD_LOAD : CMD_NONE;
			S_DEPTH: cmd.op = CMD_RD_DEPTH;
			S_ABASE: cmd.op = CMD_ADD_BASE;
			S_ARD: cmd.op = CMD_ADD_RD;
			S_ARD2: cmd.op = CMD_ADD_RD2;
			S_AWR: cmd.op = CMD_ADD_WR;
			S_SWAP: cmd.op = CMD_SWAP;
			S_L1RD: cmd.op = CMD_L1_RD;
			S_L1EV: cmd.op = CMD_L1_EV;
			S_L2RD: cmd.op = CMD_L2_RD;
			S_L2EV: cmd.op = CMD_L2_EV;
			S_FIN: cmd.op = CMD_FIN;
			default: cmd.op = CMD_NONE;
		endcase
	end

	assign capture = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q <= '0;
			fin_q <= 1'b0;
			busy_out_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (busy_out_q && out_ready) busy_out_q <= 1'b0;
			if (fin_q) busy_out_q <= 1'b1;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_DEPTH;
				S_DEPTH: begin
					if (!stat.in_range) state_q <= S_IDLE;
					else if (stat.query) state_q <= S_SWAP;
					else state_q <= S_ABASE;
					lvl_q <= 4'd1;
				end
				S_ABASE: state_q <= (LEVELS > 1) ? S_ARD : S_IDLE;
				S_ARD: state_q <= S_ARD2;
				S_ARD2: state_q <= S_AWR;
				S_AWR: begin
					if (32'(lvl_q) == LEVELS - 1) state_q <= S_IDLE;
					else begin
						lvl_q <= lvl_q + 4'd1;
						state_q <= S_ARD;
					end
				end
				S_SWAP: begin
					lvl_q <= 4'(LEVELS - 1);
					state_q <= S_L1RD;
				end
				S_L1RD: state_q <= S_L1EV;
				S_L1EV: begin
					if (lvl_q == 4'd0) begin
						lvl_q <= 4'(LEVELS - 1);
						state_q <= S_L2RD;
					end else begin
						lvl_q <= lvl_q - 4'd1;
						state_q <= S_L1RD;
					end
				end
				S_L2RD: begin
					if (stat.a_eq_b) begin
						fin_q <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_L2EV;
				end
				S_L2EV: begin
					if (lvl_q == 4'd0) state_q <= S_FIN;
					else begin
						lvl_q <= lvl_q - 4'd1;
						state_q <= S_L2RD;
					end
				end
				S_FIN: begin
					fin_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/weighted_lca_binary_lifting_core.sv -----
// Weighted lowest common ancestor core using binary lifting.
// Channels: in (valid/ready, wlca_pkg::in_item_t), out (valid/ready, out_item_t).
// opcode add attaches node_id under other_node (or as root) and fills LEVELS
// table entries; each level above 0 reads the ancestor/distance tables in two
// steps and is then written.
// opcode query lifts the deeper node, then both together, and ends early when
// one node lies on the other's root path; each lift step reads the tables in a
// registered read state before it evaluates.
// When the walk ends, fin_q is set; the result register is then loaded and out_valid rises with it.
// Adds give no result; out-of-range nodes are dropped with no result.
// One item is in flight at a time; in_ready is low while the walk runs and
// while a result waits. A stalled receiver holds the result register and
// blocks new transfers until it is taken.
// Reset clears the controller only; tables are undefined until written and
// no clearing pass is run.
`timescale 1ns / 1ps
module weighted_lca_binary_lifting_core #(
	parameter int MAX_NODES = wlca_pkg::MAX_NODES_DEF,
	parameter int LEVELS = wlca_pkg::LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wlca_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output wlca_pkg::out_item_t out_data
);
	import wlca_pkg::*;
	cmd_t cmd;
	stat_t stat;
	logic capture;
	out_item_t res;
	out_item_t out_q;

	wlca_ctrl #(.LEVELS(LEVELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
		.capture(capture)
	);

	wlca_datapath #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
		.clk(clk), .item(in_data), .cmd(cmd), .stat(stat), .result(res)
	);

	always_ff @(posedge clk) begin
		if (capture) out_q <= res;
	end
	assign out_data = out_q;
endmodule

// ----- sv/wlca_checker.sv -----
// Port-level checker for the weighted LCA core, bound to the top level.
// Depends on wlca_pkg.
`timescale 1ns / 1ps
module wlca_sva (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input wlca_pkg::out_item_t out_data
);
	import wlca_pkg::*;
	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid) else $error("result during reset");
endmodule

bind weighted_lca_binary_lifting_core wlca_sva u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
